// ----- design/m3u_pkg.sv -----
// ----------------------------------------------------------------------------
// m3u_pkg: shared types and constants of the 3x3 matrix unit
// Mode codes, sequencer states and element and field width defaults.
// ----------------------------------------------------------------------------
package m3u_pkg;

  localparam int ELEM_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int FIELD_W        = 32;

  typedef enum logic [2:0] {
    MODE_LOAD  = 3'd0,
    MODE_IDENT = 3'd1,
    MODE_TRANS = 3'd2,
    MODE_DET   = 3'd3,
    MODE_INV   = 3'd4,
    MODE_MMUL  = 3'd5,
    MODE_VMUL  = 3'd6,
    MODE_READ  = 3'd7
  } mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COF,
    ST_DET,
    ST_DIV,
    ST_ADJ,
    ST_SCALE,
    ST_MMUL,
    ST_VMUL,
    ST_DONE
  } state_t;

endpackage

// ----- design/m3u_mac.sv -----
// ----------------------------------------------------------------------------
// m3u_mac: shared multiply-accumulate unit
// One registered fixed-point product per cycle while mul_en is high, floored and
// saturated, then added to or subtracted from a wide accumulator.
// ----------------------------------------------------------------------------
module m3u_mac import m3u_pkg::*; #(
  parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    mul_en,
  input  logic signed [FIELD_W-1:0] a,
  input  logic signed [FIELD_W-1:0] b,
  input  logic                    acc_clr,
  input  logic                    acc_en,
  input  logic                    neg,
  output logic signed [FIELD_W+3:0] acc
);

  localparam int EW = (ELEM_WIDTH > FIELD_W) ? FIELD_W : ELEM_WIDTH;
  localparam int PW = 2 * FIELD_W;
  localparam int AW = FIELD_W + 4;
  localparam logic signed [PW-1:0] PMAX = PW'((64'sd1 <<< (EW - 1)) - 64'sd1);
  localparam logic signed [PW-1:0] PMIN = -PMAX - PW'(1);

  logic signed [PW-1:0]   prod_r;
  logic signed [PW-1:0]   shr;
  logic signed [FIELD_W-1:0] term;
  logic signed [AW-1:0]   acc_r;
  logic signed [AW-1:0]   acc_nxt;

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= PW'(a) * PW'(b);
    end
  end

  always_comb begin
    shr = prod_r >>> FRAC_BITS;
    if (shr > PMAX) begin
      term = FIELD_W'(PMAX);
    end else if (shr < PMIN) begin
      term = FIELD_W'(PMIN);
    end else begin
      term = FIELD_W'(shr);
    end
  end

  assign acc_nxt = neg ? acc_r - AW'(term) : acc_r + AW'(term);

  always_ff @(posedge clk) begin
    if (acc_clr) begin
      acc_r <= '0;
    end else if (acc_en) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_en ? acc_nxt : acc_r;

endmodule

// ----- design/m3u_div.sv -----
// ----------------------------------------------------------------------------
// m3u_div: sequential reciprocal divider
// Restoring division of one shifted by twice the fraction bits over the
// determinant, one quotient bit per cycle, truncated toward zero.
// ----------------------------------------------------------------------------
module m3u_div import m3u_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic signed [FIELD_W-1:0] den,
  output logic                      busy,
  output logic signed [2*FIELD_W-1:0] quo
);

  localparam int NW = 2 * FRAC_BITS + 1;
  localparam int CW = $clog2(NW + 1);
  localparam int RW = FIELD_W + 1;

  logic [NW-1:0]      num_r;
  logic [NW-1:0]      q_r;
  logic [RW-1:0]      rem_r;
  logic [FIELD_W:0]   dmag_r;
  logic               neg_r;
  logic [CW-1:0]      cnt_r;
  logic               busy_r;
  logic [RW:0]        trial;

  assign trial = {rem_r, num_r[NW-1]} - {1'b0, dmag_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(NW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r  <= NW'(1) << (2 * FRAC_BITS);
      q_r    <= '0;
      rem_r  <= '0;
      neg_r  <= den[FIELD_W-1];
      dmag_r <= den[FIELD_W-1] ? -{den[FIELD_W-1], den} : {1'b0, den};
    end else if (busy_r) begin
      num_r <= num_r << 1;
      if (!trial[RW]) begin
        rem_r <= trial[RW-1:0];
        q_r   <= {q_r[NW-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[RW-2:0], num_r[NW-1]};
        q_r   <= {q_r[NW-2:0], 1'b0};
      end
    end
  end

  assign busy = busy_r;
  assign quo  = neg_r ? -(2*FIELD_W)'(q_r) : (2*FIELD_W)'(q_r);

endmodule

// ----- design/matrix3x3_unit_core.sv -----
// ----------------------------------------------------------------------------
// matrix3x3_unit_core: stored 3x3 fixed-point matrix engine
// Every request first forms the first-row cofactors and the determinant; matrix
// and vector multiply then multiply the stored matrix by the operand, and a
// non-singular invert runs the divider and scales the adjugate. The work is
// serialised on the single shared multiplier and the bit-serial divider.
// A new request is not accepted while one is in flight; in_stall is high until the
// result is taken. Reset (synchronous, rst_n low) loads the identity matrix.
// ----------------------------------------------------------------------------
module matrix3x3_unit_core import m3u_pkg::*; #(
  parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [2:0]                in_mode,
  input  logic signed [FIELD_W-1:0] in_op_0,
  input  logic signed [FIELD_W-1:0] in_op_1,
  input  logic signed [FIELD_W-1:0] in_op_2,
  input  logic signed [FIELD_W-1:0] in_op_3,
  input  logic signed [FIELD_W-1:0] in_op_4,
  input  logic signed [FIELD_W-1:0] in_op_5,
  input  logic signed [FIELD_W-1:0] in_op_6,
  input  logic signed [FIELD_W-1:0] in_op_7,
  input  logic signed [FIELD_W-1:0] in_op_8,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [FIELD_W-1:0] out_res_0,
  output logic signed [FIELD_W-1:0] out_res_1,
  output logic signed [FIELD_W-1:0] out_res_2,
  output logic signed [FIELD_W-1:0] out_res_3,
  output logic signed [FIELD_W-1:0] out_res_4,
  output logic signed [FIELD_W-1:0] out_res_5,
  output logic signed [FIELD_W-1:0] out_res_6,
  output logic signed [FIELD_W-1:0] out_res_7,
  output logic signed [FIELD_W-1:0] out_res_8,
  output logic signed [FIELD_W-1:0] out_det_value,
  output logic                      out_singular
);

  localparam int EW = (ELEM_WIDTH > FIELD_W) ? FIELD_W : ELEM_WIDTH;
  localparam int AW = FIELD_W + 4;
  localparam logic signed [AW-1:0] EMAX = AW'((64'sd1 <<< (EW - 1)) - 64'sd1);
  localparam logic signed [AW-1:0] EMIN = -EMAX - AW'(1);
  localparam logic signed [2*FIELD_W-1:0] QMAX = (2*FIELD_W)'(EMAX);
  localparam logic signed [2*FIELD_W-1:0] QMIN = (2*FIELD_W)'(EMIN);
  localparam logic signed [FIELD_W-1:0] ONE_SAT =
    (FRAC_BITS >= EW - 1) ? FIELD_W'(EMAX) : FIELD_W'(64'sd1 <<< FRAC_BITS);

  logic signed [FIELD_W-1:0] m_r   [9];
  logic signed [FIELD_W-1:0] op_r  [9];
  logic signed [FIELD_W-1:0] t_r   [9];
  logic signed [FIELD_W-1:0] c_r   [3];
  logic signed [FIELD_W-1:0] det_r;
  logic signed [FIELD_W-1:0] recip_r;
  logic signed [FIELD_W-1:0] res_r [9];
  logic                      sing_r;
  mode_t                     mode_r;
  state_t                    st_r, st_nxt;
  logic [3:0]                idx_r, idx_nxt;
  logic [1:0]                k_r, k_nxt;
  logic                      ph_r, ph_nxt;
  logic                      out_valid_r;

  logic signed [FIELD_W-1:0] mul_a, mul_b;
  logic                      mul_en, acc_clr, acc_en, neg;
  logic signed [AW-1:0]      acc;
  logic signed [FIELD_W-1:0] acc_sat;
  logic signed [FIELD_W-1:0] acc_neg;
  logic                      div_start, div_busy;
  logic signed [2*FIELD_W-1:0] quo;
  logic signed [FIELD_W-1:0] recip_sat;
  logic                      last_k, last_term;
  logic [1:0]                nterms;
  logic [3:0]                rr, cc;
  logic [7:0]                pair;

  m3u_mac #(.ELEM_WIDTH(ELEM_WIDTH), .FRAC_BITS(FRAC_BITS)) u_mac (
    .clk(clk), .mul_en(mul_en), .a(mul_a), .b(mul_b), .acc_clr(acc_clr),
    .acc_en(acc_en), .neg(neg), .acc(acc)
  );

  m3u_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .den(det_r), .busy(div_busy),
    .quo(quo)
  );

  always_comb begin
    if (acc > EMAX) begin
      acc_sat = FIELD_W'(EMAX);
    end else if (acc < EMIN) begin
      acc_sat = FIELD_W'(EMIN);
    end else begin
      acc_sat = FIELD_W'(acc);
    end
    acc_neg = (acc_sat == FIELD_W'(EMIN)) ? FIELD_W'(EMAX) : -acc_sat;
    if (quo > QMAX) begin
      recip_sat = FIELD_W'(QMAX);
    end else if (quo < QMIN) begin
      recip_sat = FIELD_W'(QMIN);
    end else begin
      recip_sat = FIELD_W'(quo);
    end
  end

  // operand pairs: index idx within a phase, term k
  function automatic logic [7:0] cof_pair(input logic [3:0] i, input logic [1:0] k);
    logic [7:0] p;
    p = 8'h00;
    unique case (i)
      4'd0: p = (k == 2'd0) ? 8'h48 : 8'h57;
      4'd1: p = (k == 2'd0) ? 8'h18 : 8'h27;
      4'd2: p = (k == 2'd0) ? 8'h15 : 8'h24;
      4'd3: p = (k == 2'd0) ? 8'h38 : 8'h56;
      4'd4: p = (k == 2'd0) ? 8'h08 : 8'h26;
      4'd5: p = (k == 2'd0) ? 8'h05 : 8'h23;
      4'd6: p = (k == 2'd0) ? 8'h37 : 8'h46;
      4'd7: p = (k == 2'd0) ? 8'h07 : 8'h16;
      4'd8: p = (k == 2'd0) ? 8'h04 : 8'h13;
      default: p = 8'h00;
    endcase
    return p;
  endfunction

  always_comb begin
    pair = cof_pair(idx_r, k_r);
    last_k = 1'b0;
    nterms = 2'd1;
    rr = 4'd0;
    cc = 4'd0;
    mul_a = '0;
    mul_b = '0;
    neg = 1'b0;
    unique case (st_r)
      ST_COF, ST_ADJ: begin
        nterms = 2'd1;
        mul_a = m_r[pair[7:4]];
        mul_b = m_r[pair[3:0]];
        neg = (k_r == 2'd1);
      end
      ST_DET: begin
        nterms = 2'd2;
        mul_a = m_r[4'(k_r)];
        mul_b = c_r[k_r];
        neg = (k_r == 2'd1);
      end
      ST_SCALE: begin
        nterms = 2'd0;
        mul_a = recip_r;
        mul_b = t_r[idx_r];
      end
      ST_MMUL: begin
        nterms = 2'd2;
        rr = (idx_r >= 4'd6) ? 4'd6 : (idx_r >= 4'd3) ? 4'd3 : 4'd0;
        cc = idx_r - rr;
        mul_a = m_r[rr + 4'(k_r)];
        mul_b = op_r[4'(k_r) * 4'd3 + cc];
      end
      ST_VMUL: begin
        nterms = 2'd2;
        mul_a = m_r[idx_r * 4'd3 + 4'(k_r)];
        mul_b = op_r[4'(k_r)];
      end
      default: ;
    endcase
    last_k = (k_r == nterms);
  end

  assign last_term = ph_r && last_k;
  assign mul_en  = !ph_r;
  assign acc_en  = ph_r;
  assign acc_clr = (st_r == ST_IDLE) || (st_r == ST_DIV) || (st_r == ST_DONE) ||
                   last_term;

  // next state
  always_comb begin
    st_nxt = st_r;
    idx_nxt = idx_r;
    k_nxt = k_r;
    ph_nxt = ph_r;
    unique case (st_r)
      ST_IDLE: begin
        if (in_valid && !in_stall) begin
          st_nxt = ST_COF;
          idx_nxt = 4'd0;
          k_nxt = 2'd0;
          ph_nxt = 1'b0;
        end
      end
      ST_COF, ST_DET, ST_ADJ, ST_SCALE, ST_MMUL, ST_VMUL: begin
        ph_nxt = !ph_r;
        if (ph_r) begin
          k_nxt = last_k ? 2'd0 : k_r + 2'd1;
          if (last_k) begin
            idx_nxt = idx_r + 4'd1;
            unique case (st_r)
              ST_COF: begin
                if (idx_r == 4'd0) begin
                  idx_nxt = 4'd3;
                end else if (idx_r == 4'd3) begin
                  idx_nxt = 4'd6;
                end else begin
                  st_nxt = ST_DET;
                  idx_nxt = 4'd0;
                end
              end
              ST_DET: begin
                idx_nxt = 4'd0;
                unique case (mode_r)
                  MODE_INV:  st_nxt = ST_DONE;
                  MODE_MMUL: st_nxt = ST_MMUL;
                  MODE_VMUL: st_nxt = ST_VMUL;
                  default:   st_nxt = ST_DONE;
                endcase
                if (mode_r == MODE_INV && acc_sat != '0) begin
                  st_nxt = ST_DIV;
                end
              end
              ST_ADJ:   if (idx_r == 4'd8) begin st_nxt = ST_SCALE; idx_nxt = 4'd0; end
              ST_SCALE: if (idx_r == 4'd8) st_nxt = ST_DONE;
              ST_MMUL:  if (idx_r == 4'd8) st_nxt = ST_DONE;
              ST_VMUL:  if (idx_r == 4'd2) st_nxt = ST_DONE;
              default: ;
            endcase
          end
        end
      end
      ST_DIV: begin
        ph_nxt = 1'b0;
        if (ph_r && !div_busy) begin
          st_nxt = ST_ADJ;
          idx_nxt = 4'd0;
        end else begin
          ph_nxt = 1'b1;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  assign div_start = (st_r == ST_DIV) && !ph_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      idx_r <= '0;
      k_r <= '0;
      ph_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      idx_r <= idx_nxt;
      k_r <= k_nxt;
      ph_r <= ph_nxt;
      if (st_r == ST_DONE && st_nxt == ST_IDLE) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) begin
        m_r[i] <= (i % 4 == 0) ? ONE_SAT : '0;
      end
    end else begin
      if (st_r == ST_IDLE && in_valid && !in_stall) begin
        mode_r <= mode_t'(in_mode);
        sing_r <= 1'b0;
        op_r[0] <= in_op_0; op_r[1] <= in_op_1; op_r[2] <= in_op_2;
        op_r[3] <= in_op_3; op_r[4] <= in_op_4; op_r[5] <= in_op_5;
        op_r[6] <= in_op_6; op_r[7] <= in_op_7; op_r[8] <= in_op_8;
      end
      if (last_term) begin
        unique case (st_r)
          ST_COF: c_r[(idx_r == 4'd0) ? 2'd0 : (idx_r == 4'd3) ? 2'd1 : 2'd2] <= acc_sat;
          ST_DET: begin
            det_r <= acc_sat;
            if (mode_r == MODE_INV && acc_sat == '0) begin
              sing_r <= 1'b1;
            end
          end
          ST_ADJ: t_r[idx_r] <= (idx_r[0]) ? acc_neg : acc_sat;
          ST_SCALE, ST_MMUL: t_r[idx_r] <= acc_sat;
          ST_VMUL: t_r[idx_r] <= acc_sat;
          default: ;
        endcase
      end
      if (st_r == ST_DIV && ph_r && !div_busy) begin
        recip_r <= recip_sat;
      end
      if (st_r == ST_DONE && st_nxt == ST_IDLE) begin
        unique case (mode_r)
          MODE_LOAD: for (int i = 0; i < 9; i++) begin
            m_r[i] <= op_r[i];
            res_r[i] <= op_r[i];
          end
          MODE_IDENT: for (int i = 0; i < 9; i++) begin
            m_r[i] <= (i % 4 == 0) ? ONE_SAT : '0;
            res_r[i] <= (i % 4 == 0) ? ONE_SAT : '0;
          end
          MODE_TRANS: for (int i = 0; i < 9; i++) begin
            m_r[i] <= m_r[(i % 3) * 3 + i / 3];
            res_r[i] <= m_r[(i % 3) * 3 + i / 3];
          end
          MODE_INV: for (int i = 0; i < 9; i++) begin
            if (sing_r) begin
              res_r[i] <= m_r[i];
            end else begin
              m_r[i] <= t_r[i];
              res_r[i] <= t_r[i];
            end
          end
          MODE_MMUL: for (int i = 0; i < 9; i++) begin
            m_r[i] <= t_r[i];
            res_r[i] <= t_r[i];
          end
          MODE_VMUL: for (int i = 0; i < 9; i++) begin
            res_r[i] <= (i < 3) ? t_r[i] : m_r[i];
          end
          MODE_DET, MODE_READ: for (int i = 0; i < 9; i++) begin
            res_r[i] <= m_r[i];
          end
          default: for (int i = 0; i < 9; i++) begin
            res_r[i] <= m_r[i];
          end
        endcase
      end
    end
  end

  assign in_stall = (st_r != ST_IDLE) || out_valid_r;
  assign out_valid = out_valid_r;
  assign out_res_0 = res_r[0];
  assign out_res_1 = res_r[1];
  assign out_res_2 = res_r[2];
  assign out_res_3 = res_r[3];
  assign out_res_4 = res_r[4];
  assign out_res_5 = res_r[5];
  assign out_res_6 = res_r[6];
  assign out_res_7 = res_r[7];
  assign out_res_8 = res_r[8];
  assign out_det_value = det_r;
  assign out_singular = sing_r;

  ap_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != ST_IDLE) |-> in_stall)
    else $error("request accepted while busy");
  ap_div_only_inv: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> (mode_r == MODE_INV))
    else $error("divider started outside invert");
  ap_sing_inv: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_singular) |-> (mode_r == MODE_INV))
    else $error("singular flagged outside invert");

endmodule
